// ===== hdl/rc4_stream_cipher_top_macros.svh =====
// Assertion macros for the RC4 engine checker.
// Used by rc4_checker.sv; no other dependencies.
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RC4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc4 same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc4 next-cycle check failed");

`endif

// ===== hdl/rc4_pkg.sv =====
// Shared types and constants for the RC4 engine.
// No dependencies; used by rc4_ctrl, rc4_dpath and rc4_stream_cipher_top.
`default_nettype none

package rc4_pkg;

  localparam int KEY_BYTES_MAX_DEF = 32;
  localparam int TBL_DEPTH         = 256;
  localparam int BYTE_W            = 8;
  localparam int KLEN_W            = 6;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  typedef enum logic {
    OP_INIT = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_0 = 3'd0,
    CFG_KEY_WORD_1 = 3'd1,
    CFG_KEY_WORD_2 = 3'd2,
    CFG_KEY_WORD_3 = 3'd3,
    CFG_KEY_LENGTH = 3'd4
  } cfg_reg_t;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    DP_NOP     = 4'd0,
    DP_CAPTURE = 4'd1,
    DP_FILL    = 4'd2,
    DP_K_RD_N  = 4'd3,
    DP_K_RD_J  = 4'd4,
    DP_K_WR_N  = 4'd5,
    DP_K_WR_J  = 4'd6,
    DP_G_RD_I  = 4'd7,
    DP_G_RD_J  = 4'd8,
    DP_G_WR_I  = 4'd9,
    DP_G_WR_J  = 4'd10,
    DP_G_RD_K  = 4'd11,
    DP_G_KS    = 4'd12,
    DP_OUT     = 4'd13
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic n_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/rc4_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rc4_ctrl.sv =====
// Sequencer for the RC4 engine: input handshake, key schedule and byte steps.
// Depends on rc4_pkg; drives rc4_dpath through cmd_t / status_t.
`default_nettype none

module rc4_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_opcode,
  input  wire rc4_pkg::status_t status,
  output rc4_pkg::cmd_t         cmd
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0_0000_0000_0001,
    ST_FILL   = 13'b0_0000_0000_0010,
    ST_K_RD_N = 13'b0_0000_0000_0100,
    ST_K_RD_J = 13'b0_0000_0000_1000,
    ST_K_WR_N = 13'b0_0000_0001_0000,
    ST_K_WR_J = 13'b0_0000_0010_0000,
    ST_G_RD_I = 13'b0_0000_0100_0000,
    ST_G_RD_J = 13'b0_0000_1000_0000,
    ST_G_WR_I = 13'b0_0001_0000_0000,
    ST_G_WR_J = 13'b0_0010_0000_0000,
    ST_G_RD_K = 13'b0_0100_0000_0000,
    ST_G_KS   = 13'b0_1000_0000_0000,
    ST_OUT    = 13'b1_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rc4_pkg::DP_NOP;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = rc4_pkg::DP_CAPTURE;
          if (in_opcode == rc4_pkg::OP_INIT) begin
            state_nxt = ST_FILL;
          end else if (status.keyed) begin
            state_nxt = ST_G_RD_I;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_FILL: begin
        cmd.op = rc4_pkg::DP_FILL;
        if (status.n_last) begin
          state_nxt = ST_K_RD_N;
        end
      end
      ST_K_RD_N: begin
        cmd.op    = rc4_pkg::DP_K_RD_N;
        state_nxt = ST_K_RD_J;
      end
      ST_K_RD_J: begin
        cmd.op    = rc4_pkg::DP_K_RD_J;
        state_nxt = ST_K_WR_N;
      end
      ST_K_WR_N: begin
        cmd.op    = rc4_pkg::DP_K_WR_N;
        state_nxt = ST_K_WR_J;
      end
      ST_K_WR_J: begin
        cmd.op    = rc4_pkg::DP_K_WR_J;
        state_nxt = status.n_last ? ST_IDLE : ST_K_RD_N;
      end
      ST_G_RD_I: begin
        cmd.op    = rc4_pkg::DP_G_RD_I;
        state_nxt = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        cmd.op    = rc4_pkg::DP_G_RD_J;
        state_nxt = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        cmd.op    = rc4_pkg::DP_G_WR_I;
        state_nxt = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        cmd.op    = rc4_pkg::DP_G_WR_J;
        state_nxt = ST_G_RD_K;
      end
      ST_G_RD_K: begin
        cmd.op    = rc4_pkg::DP_G_RD_K;
        state_nxt = ST_G_KS;
      end
      ST_G_KS: begin
        cmd.op    = rc4_pkg::DP_G_KS;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (status.out_free) begin
          cmd.op    = rc4_pkg::DP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rc4_dpath.sv =====
// RC4 datapath: key registers, indices, permutation table and output register.
// Depends on rc4_pkg and rc4_ram; commanded by rc4_ctrl.
`default_nettype none

module rc4_dpath #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rc4_pkg::cmd_t                    cmd,
  output rc4_pkg::status_t                      status,
  input  wire logic                             in_opcode,
  input  wire logic [rc4_pkg::BYTE_W-1:0]       in_data,
  input  wire logic                             cfg_valid,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic      [rc4_pkg::BYTE_W-1:0]       out_data
);

  localparam int KIDX_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int BW     = rc4_pkg::BYTE_W;
  localparam int LW     = rc4_pkg::KLEN_W;

  logic [BW-1:0]     key_bytes_r [KEY_BYTES_MAX];
  logic [LW-1:0]     key_len_r;
  logic [LW-1:0]     key_len_eff;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;
  logic [BW-1:0]     n_r, i_r, j_r, s_r, t_r, data_r, ks_r, out_data_r;
  logic              keyed_r, out_valid_r;
  logic [BW-1:0]     key_byte, j_ksa;

  logic          ram_we;
  logic [BW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  rc4_ram #(
    .WIDTH (BW),
    .DEPTH (rc4_pkg::TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // zero length acts as one, long lengths saturate
  always_comb begin
    if (key_len_r == '0) begin
      key_len_eff = LW'(1);
    end else if (key_len_r > LW'(KEY_BYTES_MAX)) begin
      key_len_eff = LW'(KEY_BYTES_MAX);
    end else begin
      key_len_eff = key_len_r;
    end
  end

  // key index runs n mod length as a wrapping counter
  assign kidx_nxt = (LW'(kidx_r) == key_len_eff - LW'(1)) ? '0 : kidx_r + KIDX_W'(1);
  assign key_byte = key_bytes_r[kidx_r];
  assign j_ksa    = j_r + ram_rdata + key_byte;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n_r;
    ram_wdata = n_r;
    ram_raddr = n_r;
    unique case (cmd.op)
      rc4_pkg::DP_FILL: begin
        ram_we = 1'b1;
      end
      rc4_pkg::DP_K_RD_J: begin
        ram_raddr = j_ksa;
      end
      rc4_pkg::DP_K_WR_N: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      rc4_pkg::DP_K_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = s_r;
      end
      rc4_pkg::DP_G_RD_I: begin
        ram_raddr = i_r + BW'(1);
      end
      rc4_pkg::DP_G_RD_J: begin
        ram_raddr = j_r + ram_rdata;
      end
      rc4_pkg::DP_G_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
      end
      rc4_pkg::DP_G_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = s_r;
      end
      rc4_pkg::DP_G_RD_K: begin
        ram_raddr = s_r + t_r;
      end
      default: begin
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      key_len_r   <= LW'(1);
      for (int b = 0; b < KEY_BYTES_MAX; b++) begin
        key_bytes_r[b] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        for (int b = 0; b < KEY_BYTES_MAX; b++) begin
          if (cfg_index == rc4_pkg::CFG_IDX_W'(b >> 3)) begin
            key_bytes_r[b] <= cfg_data[(b & 7) * BW +: BW];
          end
        end
        if (cfg_index == rc4_pkg::CFG_KEY_LENGTH) begin
          key_len_r <= cfg_data[LW-1:0];
        end
      end
      // a new byte only loads once the old one is free or leaving
      if (cmd.op == rc4_pkg::DP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        rc4_pkg::DP_CAPTURE: begin
          if (in_opcode == rc4_pkg::OP_INIT) begin
            j_r <= '0;
          end
        end
        rc4_pkg::DP_K_RD_J: begin
          j_r <= j_ksa;
        end
        rc4_pkg::DP_K_WR_J: begin
          if (n_r == '1) begin
            keyed_r <= 1'b1;
            i_r     <= '0;
            j_r     <= '0;
          end
        end
        rc4_pkg::DP_G_RD_I: begin
          i_r <= i_r + BW'(1);
        end
        rc4_pkg::DP_G_RD_J: begin
          j_r <= j_r + ram_rdata;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rc4_pkg::DP_CAPTURE: begin
        data_r <= in_data;
        ks_r   <= '0;
        n_r    <= '0;
        kidx_r <= '0;
      end
      rc4_pkg::DP_FILL: begin
        n_r <= n_r + BW'(1);
      end
      rc4_pkg::DP_K_RD_J: begin
        s_r <= ram_rdata;
      end
      rc4_pkg::DP_K_WR_J: begin
        n_r    <= n_r + BW'(1);
        kidx_r <= kidx_nxt;
      end
      rc4_pkg::DP_G_RD_J: begin
        s_r <= ram_rdata;
      end
      rc4_pkg::DP_G_WR_I: begin
        t_r <= ram_rdata;
      end
      rc4_pkg::DP_G_KS: begin
        ks_r <= ram_rdata;
      end
      rc4_pkg::DP_OUT: begin
        out_data_r <= data_r ^ ks_r;
      end
      default: begin
      end
    endcase
  end

  assign status.keyed    = keyed_r;
  assign status.n_last   = (n_r == '1);
  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/rc4_stream_cipher_top.sv =====
// Top level of the RC4 stream cipher engine.
// Depends on rc4_pkg, rc4_ctrl, rc4_dpath (and through it rc4_ram).
`default_nettype none

// RC4 engine with stream ports. Write the key into the four key word registers
// (byte 0 in the low bits of word 0) and the key length (1..32, zero reads as
// one, larger values saturate) through the cfg_ port, which is always ready.
// Then send an initialize request (in_tuser = 0): it runs the key schedule and
// gives no output, and the next request is taken only once it ends (a fill of
// all 256 table entries, then 256 swap steps of two reads and two writes each).
// A data request (in_tuser = 1) returns in_tdata XOR one keystream byte; the
// next request is taken only after the chain of dependent reads and writes on
// the single read / single write table memory (read S[i], read S[j], two swap
// writes, keystream read, output), and the output step waits for a free output
// register. Data sent before the first initialize comes back unchanged. One
// request is worked on at a time; a finished byte sits in the output register,
// so a new request is taken while the result waits for out_tready. The table
// holds no meaningful contents until the first initialize.
module rc4_stream_cipher_top #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_in
  input  wire logic [0:0]                     in_tuser,   // [0] opcode
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [7:0]                     out_tdata,  // [7:0] data_out
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data
);

  rc4_pkg::cmd_t    cmd;
  rc4_pkg::status_t status;

  // registers are plain flops, writes never stall
  assign cfg_ready = 1'b1;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser[0]),
    .status    (status),
    .cmd       (cmd)
  );

  rc4_dpath #(
    .KEY_BYTES_MAX (KEY_BYTES_MAX)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_opcode  (in_tuser[0]),
    .in_data    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/rc4_checker.sv =====
// Port-level checks for the RC4 engine, bound to the top level.
// Depends on rc4_stream_cipher_top_macros.svh.
`default_nettype none

`include "rc4_stream_cipher_top_macros.svh"

module rc4_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [7:0]                     out_tdata
);

  // a stalled result holds
  `RC4_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time: busy right after an accept
  `RC4_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // no result appears in the cycle after an accept
  `RC4_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_tvalid && in_tready && !out_tvalid, !out_tvalid)

  // a new result goes out as the engine turns ready again
  `RC4_ASSERT_NOW(a_ready_with_result, clk, rst_n, $rose(out_tvalid), in_tready)

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);

`default_nettype wire

// ===== test/rc4_checker.sv =====
// Scoreboard for the RC4 engine: tracks key registers and cipher state from
// the observed handshakes and compares every output byte against its own model.
// Depends on rc4_pkg for field widths, opcodes and register indexes.
module rc4_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic [0:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [CFG_DATA_W-1:0] key_words [4];
  logic [KLEN_W-1:0]     key_len;
  logic [BYTE_W-1:0]     sbox [TBL_DEPTH];
  logic [BYTE_W-1:0]     idx_i;
  logic [BYTE_W-1:0]     idx_j;
  logic                  keyed;
  logic [BYTE_W-1:0]     cipher_bytes_due [$];
  logic [BYTE_W-1:0]     wanted;

  function automatic logic [BYTE_W-1:0] key_byte(int unsigned n);
    logic [4:0] pos;
    pos = n[4:0];
    return key_words[pos[4:3]][pos[2:0]*8 +: 8];
  endfunction

  // Key schedule: identity fill, then 256 swap steps driven by the key
  task automatic run_key_schedule();
    int unsigned      len;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] s;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_BYTES_MAX_DEF) len = KEY_BYTES_MAX_DEF;
    for (int n = 0; n < TBL_DEPTH; n++) sbox[n] = n[BYTE_W-1:0];
    j = '0;
    for (int unsigned n = 0; n < TBL_DEPTH; n++) begin
      s = sbox[n];
      j = j + s + key_byte(n % len);
      sbox[n] = sbox[j];
      sbox[j] = s;
    end
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b1;
  endtask

  // One generator step; unkeyed engine passes data straight through
  function automatic logic [BYTE_W-1:0] next_cipher_byte(logic [BYTE_W-1:0] din);
    logic [BYTE_W-1:0] si;
    logic [BYTE_W-1:0] sj;
    if (!keyed) return din;
    idx_i = idx_i + 8'd1;
    si = sbox[idx_i];
    idx_j = idx_j + si;
    sj = sbox[idx_j];
    sbox[idx_i] = sj;
    sbox[idx_j] = si;
    return din ^ sbox[BYTE_W'(si + sj)];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (key_words[w]) key_words[w] = '0;
      key_len = KLEN_W'(1);
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b0;
      cipher_bytes_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_KEY_WORD_0: key_words[0] = cfg_data;
          CFG_KEY_WORD_1: key_words[1] = cfg_data;
          CFG_KEY_WORD_2: key_words[2] = cfg_data;
          CFG_KEY_WORD_3: key_words[3] = cfg_data;
          CFG_KEY_LENGTH: key_len = cfg_data[KLEN_W-1:0];
          default: ;  // spare indexes are dropped
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (cipher_bytes_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("[%0t] data_out %02h with no request outstanding", $time, out_tdata);
          fail_count++;
        end else begin
          wanted = cipher_bytes_due.pop_front();
          if (out_tdata !== wanted) begin
            if (fail_count < MAX_REPORTS)
              $display("[%0t] data_out mismatch: expected %02h, got %02h",
                       $time, wanted, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser[0]) == OP_DATA)
          cipher_bytes_due.push_back(next_cipher_byte(in_tdata));
        else
          run_key_schedule();
      end
    end
    bytes_due = cipher_bytes_due.size();
  end

endmodule

// ===== test/tb_rc4_stream_cipher_top.sv =====
// Testbench top for the RC4 stream cipher engine: drives requests, register
// writes and output back-pressure, and gives the verdict.
// Depends on rc4_pkg, rc4_stream_cipher_top and rc4_scoreboard.
module tb_rc4_stream_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4_pkg::*;

  // A key schedule occupies the engine and yields nothing, so before touching
  // the key registers we wait long enough for one to finish.
  localparam int SCHEDULE_SETTLE = 1400;
  // Longest legitimate quiet stretch is a schedule followed by a settle pause.
  localparam int QUIET_LIMIT     = 20000;
  localparam int RESET_CYCLES    = 7;
  localparam int RUN_LENGTH      = 290;
  localparam int PHASES          = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_KEY_LENGTH) + 1'b1;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [7:0]            in_tdata   = '0;   // [7:0] data_in
  logic [0:0]            in_tuser   = '0;   // [0] opcode
  wire                   in_tready;
  wire                   out_tvalid;
  logic                  out_tready = 1'b1;
  wire  [7:0]            out_tdata;         // [7:0] data_out
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  wire                   cfg_ready;

  int fail_count;
  int bytes_due;
  int quiet_cycles = 0;

  // Idle controls: gaps on the request side, stalls on the output side
  bit in_gaps    = 1'b0;
  bit out_stalls = 1'b0;

  always #10 clk = ~clk;

  rc4_stream_cipher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rc4_scoreboard scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .bytes_due  (bytes_due)
  );

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_rc4_stream_cipher_top failed");
      $finish;
    end
  end

  // Output back-pressure: random stall bursts when enabled
  always begin
    @(negedge clk);
    if (out_stalls && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  // One request; returns on the falling edge after acceptance with tvalid
  // still high, so back-to-back requests keep it asserted.
  task automatic send_request(op_t op, logic [7:0] payload);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Full key load plus one write to a spare index, which must be dropped
  task automatic load_key(logic [CFG_DATA_W-1:0] w0, logic [CFG_DATA_W-1:0] w1,
                          logic [CFG_DATA_W-1:0] w2, logic [CFG_DATA_W-1:0] w3,
                          logic [KLEN_W-1:0] len);
    write_reg(CFG_KEY_WORD_0, w0);
    write_reg(CFG_KEY_WORD_1, w1);
    write_reg(CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
    write_reg(CFG_KEY_WORD_2, w2);
    write_reg(CFG_KEY_WORD_3, w3);
    write_reg(CFG_KEY_LENGTH, CFG_DATA_W'(len));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain outstanding bytes, then cover a key schedule that may still be running
  task automatic settle();
    in_tvalid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (SCHEDULE_SETTLE) @(negedge clk);
  endtask

  // Long keystream runs with the odd re-key; idle modes change every 100 requests unless tail is set
  task automatic random_run(int count, bit tail);
    op_t op;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0 && !tail) begin
        in_gaps    = $urandom_range(0, 2) != 0;
        out_stalls = $urandom_range(0, 2) != 0;
      end
      op = ($urandom_range(0, 199) == 0) ? OP_INIT : OP_DATA;
      send_request(op, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [KLEN_W-1:0]     len;
    logic [CFG_DATA_W-1:0] words [4];

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unkeyed engine: bytes come back unchanged
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h5A);
    // Schedule with the reset key: one zero byte; data field ignored
    send_request(OP_INIT, 8'hFF);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'hA5);
    // Back-to-back schedules restart the keystream from the top
    send_request(OP_INIT, 8'h00);
    send_request(OP_INIT, 8'hAA);
    send_request(OP_DATA, 8'h3C);
    send_request(OP_DATA, 8'hC3);
    settle();

    // Longest key, all ones; first bytes still use the previous table
    load_key('1, '1, '1, '1, KLEN_W'(KEY_BYTES_MAX_DEF));
    send_request(OP_DATA, 8'h81);
    send_request(OP_DATA, 8'h7E);
    send_request(OP_INIT, 8'h00);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    settle();

    // Random phases over a spread of key lengths, including zero (read as
    // one) and oversize values that saturate to the maximum
    for (int p = 0; p < PHASES; p++) begin
      foreach (words[w]) words[w] = {$urandom, $urandom};
      case (p)
        0: len = KLEN_W'(1);
        1: len = '0;
        2: len = '1;
        3: begin
          len = KLEN_W'(KEY_BYTES_MAX_DEF + 1);
          foreach (words[w]) words[w] = '0;
        end
        4: len = KLEN_W'(KEY_BYTES_MAX_DEF);
        5: len = KLEN_W'($urandom_range(2, KEY_BYTES_MAX_DEF - 1));
        default: len = KLEN_W'($urandom_range(1, KEY_BYTES_MAX_DEF));
      endcase
      // last phase runs flat out on both sides
      if (p == PHASES - 1) begin
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
      end
      load_key(words[0], words[1], words[2], words[3], len);
      repeat ($urandom_range(0, 4)) send_request(OP_DATA, 8'($urandom_range(0, 255)));
      send_request(OP_INIT, 8'($urandom_range(0, 255)));
      random_run(RUN_LENGTH, p == PHASES - 1);
      settle();
    end

    if (fail_count == 0 && bytes_due == 0)
      $display("tb_rc4_stream_cipher_top passed");
    else
      $display("tb_rc4_stream_cipher_top failed");
    $finish;
  end

endmodule
